// ===== design/u8u16d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8u16d_pkg;

	localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

	// Register indexes of the configuration port
	localparam logic REG_CONSOLE_MODE = 1'b0;

	// Sequence length codes returned by seq_len
	localparam logic [2:0] LEN_CONT = 3'd0;
	localparam logic [2:0] LEN_1    = 3'd1;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} unit_t;

	// Bytes 0xF8 to 0xFF fall in with the continuation bytes.
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		case (b) inside
			[8'h00:8'h7F]: len = LEN_1;
			[8'hC0:8'hDF]: len = LEN_2;
			[8'hE0:8'hEF]: len = LEN_3;
			[8'hF0:8'hF7]: len = LEN_4;
			default:       len = LEN_CONT;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== design/utf8_to_utf16_stream_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 to UTF-16 stream decoder. One byte is taken per clock cycle on the
// input channel; each byte yields zero, one or two UTF-16 code units, the last
// of them flagged by last_unit. A byte is registered on acceptance and decoded
// from that register against the pending-sequence state, and its units pass
// through the unit queue to the output. Results wait in a four-entry unit
// queue that drains one unit per cycle while out_stall is low; the input stalls
// only while the byte register holds a beat and the queue has fewer than two
// free entries, which happens only when the output side stalls. console_mode
// (reset 1, byte address 0) selects decoding; with it clear every byte goes out
// unchanged as one unit and the pending sequence is left as it was.
module utf8_to_utf16_stream_decoder_unit
	import u8u16d_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      code_unit,
	output logic             last_unit,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int QDEPTH = 4;

	logic        console_mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  pend0_q, pend1_q, pend2_q;
	logic [1:0]  pend_cnt_q;
	unit_t       queue_q [QDEPTH];
	logic [1:0]  rd_ptr_q, wr_ptr_q;
	logic [2:0]  count_q;

	logic        advance, pop;
	logic [1:0]  n_res;
	unit_t       unit0, unit1;
	logic [1:0]  cnt_nx;
	logic        store_en;
	logic [1:0]  store_idx;
	logic [2:0]  len, expect_len;
	logic [20:0] cp4;
	logic [31:0] v;

	// Configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CONSOLE_MODE) begin
			prdata = {31'b0, console_mode_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CONSOLE_MODE) begin
			console_mode_q <= pwdata[0];
		end
	end

	// Handshakes
	assign advance  = valid_s1 && (count_q <= 3'(QDEPTH - 2));
	assign in_stall = valid_s1 && !advance;
	assign out_valid = (count_q != 3'd0);
	assign pop       = out_valid && !out_stall;
	assign code_unit = queue_q[rd_ptr_q].code_unit;
	assign last_unit = queue_q[rd_ptr_q].last_unit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode of the registered byte against the open sequence
	assign cp4 = {pend0_q[2:0], pend1_q[5:0], pend2_q[5:0], byte_s1[5:0]};
	assign v   = {11'b0, cp4} - 32'h0001_0000;

	always_comb begin
		len        = seq_len(byte_s1);
		expect_len = seq_len(pend0_q);
		n_res      = 2'd0;
		unit0      = '{code_unit: REPLACEMENT_UNIT, last_unit: 1'b1};
		unit1      = '{code_unit: {8'b0, byte_s1}, last_unit: 1'b1};
		cnt_nx     = pend_cnt_q;
		store_en   = 1'b0;
		store_idx  = 2'd0;
		if (!console_mode_q) begin
			n_res = 2'd1;
			unit0 = '{code_unit: {8'b0, byte_s1}, last_unit: 1'b1};
		end else if (len != LEN_CONT) begin
			// A lead or ASCII byte first flushes any open sequence.
			if (pend_cnt_q != 2'd0) begin
				unit0.last_unit = (len != LEN_1);
				n_res  = 2'd1;
				cnt_nx = 2'd0;
			end
			if (len == LEN_1) begin
				if (pend_cnt_q != 2'd0) begin
					n_res = 2'd2;
				end else begin
					n_res = 2'd1;
					unit0 = unit1;
				end
			end else begin
				store_en  = 1'b1;
				store_idx = 2'd0;
				cnt_nx    = 2'd1;
			end
		end else if (pend_cnt_q == 2'd0) begin
			n_res = 2'd1;
		end else if ({1'b0, pend_cnt_q} + 3'd1 < expect_len) begin
			store_en  = 1'b1;
			store_idx = pend_cnt_q;
			cnt_nx    = pend_cnt_q + 2'd1;
		end else begin
			cnt_nx = 2'd0;
			n_res  = 2'd1;
			case (expect_len)
				LEN_2: unit0.code_unit = {5'b0, pend0_q[4:0], byte_s1[5:0]};
				LEN_3: unit0.code_unit = {pend0_q[3:0], pend1_q[5:0], byte_s1[5:0]};
				LEN_4: begin
					n_res = 2'd2;
					unit0 = '{code_unit: 16'hD800 + v[25:10], last_unit: 1'b0};
					unit1 = '{code_unit: 16'hDC00 + {6'b0, v[9:0]}, last_unit: 1'b1};
				end
				default: n_res = 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (advance) begin
			pend_cnt_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_en) begin
			case (store_idx)
				2'd0:    pend0_q <= byte_s1;
				2'd1:    pend1_q <= byte_s1;
				default: pend2_q <= byte_s1;
			endcase
		end
	end

	// Unit queue
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= unit0;
			if (n_res == 2'd2) begin
				queue_q[wr_ptr_q + 2'd1] <= unit1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (advance ? {1'b0, n_res} : 3'd0) - {2'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("unit queue holds more entries than it has");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> count_q <= 3'(QDEPTH - 2))
		else $error("decode advanced without room for two units");

	a_pending_shorter: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q != 2'd0 |-> {1'b0, pend_cnt_q} < seq_len(pend0_q))
		else $error("pending count reached the sequence length");

	a_raw_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !console_mode_q |=> $stable(pend_cnt_q))
		else $error("raw byte disturbed the pending sequence");
`endif

endmodule

`default_nettype wire
